// File: rtl/dopq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the dual order process queue
// no dependencies

package dopq_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int LIST_MAX    = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;
    localparam int IDXW        = $clog2(CAPACITY);
    localparam int CNTW        = $clog2(CAPACITY + 1);
    localparam int TIMEW       = 17;

    typedef enum logic [3:0] {
        F_ADD    = 4'd0,
        F_POP_P  = 4'd1,
        F_POP_T  = 4'd2,
        F_PEEK_P = 4'd3,
        F_PEEK_T = 4'd4,
        F_CHG_P  = 4'd5,
        F_CHG_T  = 4'd6,
        F_LIST_P = 4'd7,
        F_LIST_T = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_WR,
        S_WALK_RD,
        S_WALK_CMP,
        S_WALK_END,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_LIST_RD,
        S_LIST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ADD_P,
        PH_ADD_T,
        PH_FIND,
        PH_REINS
    } t_phase;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  priority_req;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] tag;
        logic [7:0]  new_priority;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_priority;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [15:0] out_tag;
        logic        entry_valid;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0]       prio;
        logic [TIMEW-1:0] tm;
        logic [15:0]      tag;
    } t_slot;

    typedef struct packed {
        logic            ins;
        logic            rem;
        logic [CNTW-1:0] pos;
        logic [IDXW-1:0] val;
    } t_list_ctl;

endpackage

// File: rtl/dopq_slot_ram.sv
`timescale 1ns / 1ps
// slot data memory: priority, arrival time and tag per slot
// one write port, one read port with registered read data; uses dopq_pkg

module dopq_slot_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [dopq_pkg::IDXW-1:0] i_waddr,
    input  dopq_pkg::t_slot           i_wdata,
    input  logic [dopq_pkg::IDXW-1:0] i_raddr,
    output dopq_pkg::t_slot           o_rdata
);

    dopq_pkg::t_slot mem [dopq_pkg::CAPACITY];
    dopq_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dopq_rank_list.sv
`timescale 1ns / 1ps
// one order: slot numbers by position, with insert, remove and slot lookup
// uses dopq_pkg

module dopq_rank_list (
    input  logic                      i_clk,
    input  dopq_pkg::t_list_ctl       i_ctl,
    input  logic [dopq_pkg::IDXW-1:0] i_rd_idx,
    input  logic [dopq_pkg::IDXW-1:0] i_find_slot,
    output logic [dopq_pkg::IDXW-1:0] o_rd_slot,
    output logic [dopq_pkg::IDXW-1:0] o_head,
    output logic [dopq_pkg::CNTW-1:0] o_find_pos
);

    logic [dopq_pkg::IDXW-1:0] r_list [dopq_pkg::CAPACITY];
    logic [dopq_pkg::IDXW-1:0] n_list [dopq_pkg::CAPACITY];
    logic                      found;

    always_comb begin
        for (int i = 0; i < dopq_pkg::CAPACITY; i++) begin
            n_list[i] = r_list[i];
        end
        if (i_ctl.ins) begin
            if (i_ctl.pos == '0) begin
                n_list[0] = i_ctl.val;
            end
            for (int i = 1; i < dopq_pkg::CAPACITY; i++) begin
                if (dopq_pkg::CNTW'(i) == i_ctl.pos) begin
                    n_list[i] = i_ctl.val;
                end else if (dopq_pkg::CNTW'(i) > i_ctl.pos) begin
                    n_list[i] = r_list[i-1];
                end
            end
        end else if (i_ctl.rem) begin
            for (int i = 0; i < dopq_pkg::CAPACITY - 1; i++) begin
                if (dopq_pkg::CNTW'(i) >= i_ctl.pos) begin
                    n_list[i] = r_list[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < dopq_pkg::CAPACITY; i++) begin
            r_list[i] <= n_list[i];
        end
    end

    // first position holding the slot; live positions come first
    always_comb begin
        o_find_pos = '0;
        found      = 1'b0;
        for (int i = 0; i < dopq_pkg::CAPACITY; i++) begin
            if (!found && r_list[i] == i_find_slot) begin
                o_find_pos = dopq_pkg::CNTW'(i);
                found      = 1'b1;
            end
        end
    end

    assign o_rd_slot = r_list[i_rd_idx];
    assign o_head    = r_list[0];

endmodule

// File: rtl/dual_order_process_queue.sv
`timescale 1ns / 1ps
// top level: command sequencer over the slot memory and the two rank lists
// uses dopq_pkg, dopq_slot_ram, dopq_rank_list

// Takes one command when start is high and busy is low, and holds busy until
// its last result beat has gone out. Every result beat is shown on o_res for
// exactly one cycle with o_strobe high; the receiver cannot stall it, so it
// must take each beat as it comes. Entries live in a one-port-read slot
// memory, and every walk over an order reads, then compares, each entry
// examined. Full and empty replies need no walk and come out in the cycle
// after start; not-found replies come out once the walk is done. Unused
// codes give no beat.
module dual_order_process_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dopq_pkg::t_in  i_cmd,
    output dopq_pkg::t_out o_res,
    output logic           o_strobe
);

    localparam int CAP  = dopq_pkg::CAPACITY;
    localparam int IDXW = dopq_pkg::IDXW;
    localparam int CNTW = dopq_pkg::CNTW;

    dopq_pkg::t_state r_state, n_state;
    dopq_pkg::t_in    r_cmd, n_cmd;
    dopq_pkg::t_phase r_phase, n_phase;
    logic             r_ord, n_ord;
    logic [CNTW-1:0]  r_idx, n_idx;
    logic [CNTW-1:0]  r_lim, n_lim;
    logic             r_hit, n_hit;
    dopq_pkg::t_slot  r_ent, n_ent;
    logic [IDXW-1:0]  r_slot, n_slot;
    logic [CAP-1:0]   r_used, n_used;
    logic [CNTW-1:0]  r_count, n_count;
    dopq_pkg::t_out   r_res, n_res;
    logic             r_strobe, n_strobe;

    logic             ram_we;
    logic [IDXW-1:0]  ram_waddr, ram_raddr;
    dopq_pkg::t_slot  ram_wdata, ram_rdata;

    dopq_pkg::t_list_ctl ctl_p, ctl_t;
    logic [IDXW-1:0]  p_rd, t_rd, p_head, t_head, cur_rd;
    logic [CNTW-1:0]  p_find, t_find;

    logic [IDXW-1:0]  free_slot;
    logic             free_hit;
    logic             is_full, is_empty, stop;
    dopq_pkg::t_func  in_func, cur_func;
    logic [7:0]       key_p;
    logic [dopq_pkg::TIMEW-1:0] key_t;
    logic [CNTW-1:0]  list_lim;

    dopq_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dopq_rank_list u_prio (
        .i_clk       (i_clk),
        .i_ctl       (ctl_p),
        .i_rd_idx    (r_idx[IDXW-1:0]),
        .i_find_slot (r_slot),
        .o_rd_slot   (p_rd),
        .o_head      (p_head),
        .o_find_pos  (p_find)
    );

    dopq_rank_list u_time (
        .i_clk       (i_clk),
        .i_ctl       (ctl_t),
        .i_rd_idx    (r_idx[IDXW-1:0]),
        .i_find_slot (r_slot),
        .o_rd_slot   (t_rd),
        .o_head      (t_head),
        .o_find_pos  (t_find)
    );

    function automatic dopq_pkg::t_out make_res(dopq_pkg::t_status st,
                                               dopq_pkg::t_slot e,
                                               logic v, logic lst);
        dopq_pkg::t_out r;
        r = '0;
        r.status = st;
        if (v) begin
            r.out_priority = e.prio;
            r.out_hour     = e.tm[16:12];
            r.out_minute   = e.tm[11:6];
            r.out_second   = e.tm[5:0];
            r.out_tag      = e.tag;
            r.entry_valid  = 1'b1;
        end
        r.last = lst;
        return r;
    endfunction

    always_comb begin
        free_slot = '0;
        free_hit  = 1'b0;
        for (int i = 0; i < CAP; i++) begin
            if (!free_hit && !r_used[i]) begin
                free_slot = IDXW'(i);
                free_hit  = 1'b1;
            end
        end
    end

    assign in_func  = dopq_pkg::t_func'(i_cmd.func);
    assign cur_func = dopq_pkg::t_func'(r_cmd.func);
    assign is_full  = (r_count == CNTW'(CAP)) || !free_hit;
    assign is_empty = (r_count == '0);
    assign cur_rd   = r_ord ? t_rd : p_rd;
    assign list_lim = (r_count > CNTW'(dopq_pkg::LIST_MAX)) ?
                      CNTW'(dopq_pkg::LIST_MAX) : r_count;
    assign key_p    = (r_phase == dopq_pkg::PH_REINS) ? r_cmd.new_priority
                                                      : r_cmd.priority_req;
    assign key_t    = (r_phase == dopq_pkg::PH_REINS) ?
                      {r_cmd.new_hour, r_cmd.new_minute, r_cmd.new_second} :
                      {r_cmd.hour, r_cmd.minute, r_cmd.second};

    // priority order is descending with new ahead of equals; time ascending likewise
    always_comb begin
        if (!r_ord) begin
            stop = (r_phase == dopq_pkg::PH_FIND) ? (ram_rdata.prio == key_p)
                                                  : (ram_rdata.prio <= key_p);
        end else begin
            stop = (r_phase == dopq_pkg::PH_FIND) ? (ram_rdata.tm == key_t)
                                                  : (ram_rdata.tm >= key_t);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dopq_pkg::S_IDLE: begin
                if (start) begin
                    unique case (in_func)
                        dopq_pkg::F_ADD:
                            n_state = is_full ? dopq_pkg::S_IDLE : dopq_pkg::S_ADD_WR;
                        dopq_pkg::F_POP_P, dopq_pkg::F_POP_T,
                        dopq_pkg::F_PEEK_P, dopq_pkg::F_PEEK_T:
                            n_state = is_empty ? dopq_pkg::S_IDLE : dopq_pkg::S_EMIT_RD;
                        dopq_pkg::F_CHG_P, dopq_pkg::F_CHG_T:
                            n_state = dopq_pkg::S_WALK_RD;
                        dopq_pkg::F_LIST_P, dopq_pkg::F_LIST_T:
                            n_state = is_empty ? dopq_pkg::S_IDLE : dopq_pkg::S_LIST_RD;
                        default:
                            n_state = dopq_pkg::S_IDLE;
                    endcase
                end
            end
            dopq_pkg::S_ADD_WR:   n_state = dopq_pkg::S_WALK_RD;
            dopq_pkg::S_WALK_RD:
                n_state = (r_idx >= r_lim) ? dopq_pkg::S_WALK_END : dopq_pkg::S_WALK_CMP;
            dopq_pkg::S_WALK_CMP:
                n_state = stop ? dopq_pkg::S_WALK_END : dopq_pkg::S_WALK_RD;
            dopq_pkg::S_WALK_END: begin
                unique case (r_phase)
                    dopq_pkg::PH_ADD_P: n_state = dopq_pkg::S_WALK_RD;
                    dopq_pkg::PH_ADD_T: n_state = dopq_pkg::S_EMIT_RD;
                    dopq_pkg::PH_FIND:
                        n_state = r_hit ? dopq_pkg::S_WALK_RD : dopq_pkg::S_IDLE;
                    dopq_pkg::PH_REINS: n_state = dopq_pkg::S_EMIT_RD;
                    default:            n_state = dopq_pkg::S_IDLE;
                endcase
            end
            dopq_pkg::S_EMIT_RD:  n_state = dopq_pkg::S_EMIT_OUT;
            dopq_pkg::S_EMIT_OUT: n_state = dopq_pkg::S_IDLE;
            dopq_pkg::S_LIST_RD:  n_state = dopq_pkg::S_LIST_OUT;
            dopq_pkg::S_LIST_OUT:
                n_state = (r_idx + CNTW'(1) == r_lim) ? dopq_pkg::S_IDLE
                                                      : dopq_pkg::S_LIST_RD;
            default:              n_state = dopq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_ord     = r_ord;
        n_idx     = r_idx;
        n_lim     = r_lim;
        n_hit     = r_hit;
        n_ent     = r_ent;
        n_slot    = r_slot;
        n_used    = r_used;
        n_count   = r_count;
        n_res     = '0;
        n_strobe  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = r_ent;
        ram_raddr = r_slot;
        ctl_p     = '0;
        ctl_t     = '0;
        unique case (r_state)
            dopq_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_idx = '0;
                    unique case (in_func)
                        dopq_pkg::F_ADD: begin
                            if (is_full) begin
                                n_res    = make_res(dopq_pkg::ST_FULL, r_ent, 1'b0, 1'b1);
                                n_strobe = 1'b1;
                            end else begin
                                n_slot = free_slot;
                            end
                        end
                        dopq_pkg::F_POP_P, dopq_pkg::F_POP_T,
                        dopq_pkg::F_PEEK_P, dopq_pkg::F_PEEK_T: begin
                            if (is_empty) begin
                                n_res    = make_res(dopq_pkg::ST_EMPTY, r_ent, 1'b0, 1'b1);
                                n_strobe = 1'b1;
                            end else begin
                                n_slot = (in_func == dopq_pkg::F_POP_P ||
                                          in_func == dopq_pkg::F_PEEK_P) ? p_head : t_head;
                            end
                        end
                        dopq_pkg::F_CHG_P, dopq_pkg::F_CHG_T: begin
                            n_lim   = r_count;
                            n_ord   = (in_func == dopq_pkg::F_CHG_T);
                            n_phase = dopq_pkg::PH_FIND;
                        end
                        dopq_pkg::F_LIST_P, dopq_pkg::F_LIST_T: begin
                            if (is_empty) begin
                                n_res    = make_res(dopq_pkg::ST_EMPTY, r_ent, 1'b0, 1'b1);
                                n_strobe = 1'b1;
                            end else begin
                                n_lim = list_lim;
                                n_ord = (in_func == dopq_pkg::F_LIST_T);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dopq_pkg::S_ADD_WR: begin
                ram_we         = 1'b1;
                ram_wdata.prio = r_cmd.priority_req;
                ram_wdata.tm   = {r_cmd.hour, r_cmd.minute, r_cmd.second};
                ram_wdata.tag  = r_cmd.tag;
                n_used[r_slot] = 1'b1;
                n_idx          = '0;
                n_lim          = r_count;
                n_ord          = 1'b0;
                n_phase        = dopq_pkg::PH_ADD_P;
            end
            dopq_pkg::S_WALK_RD: begin
                ram_raddr = cur_rd;
                if (r_idx >= r_lim) begin
                    n_hit = 1'b0;
                end
            end
            dopq_pkg::S_WALK_CMP: begin
                if (stop) begin
                    n_hit = 1'b1;
                    n_ent = ram_rdata;
                end else begin
                    n_idx = r_idx + CNTW'(1);
                end
            end
            dopq_pkg::S_WALK_END: begin
                unique case (r_phase)
                    dopq_pkg::PH_ADD_P: begin
                        ctl_p   = '{ins: 1'b1, rem: 1'b0, pos: r_idx, val: r_slot};
                        n_idx   = '0;
                        n_lim   = r_count;
                        n_ord   = 1'b1;
                        n_phase = dopq_pkg::PH_ADD_T;
                    end
                    dopq_pkg::PH_ADD_T: begin
                        ctl_t   = '{ins: 1'b1, rem: 1'b0, pos: r_idx, val: r_slot};
                        n_count = r_count + CNTW'(1);
                    end
                    dopq_pkg::PH_FIND: begin
                        if (!r_hit) begin
                            n_res    = make_res(dopq_pkg::ST_NOT_FOUND, r_ent, 1'b0, 1'b1);
                            n_strobe = 1'b1;
                        end else begin
                            // take the matched slot out of its order and rewrite its key
                            if (r_ord) begin
                                ctl_t = '{ins: 1'b0, rem: 1'b1, pos: r_idx, val: cur_rd};
                            end else begin
                                ctl_p = '{ins: 1'b0, rem: 1'b1, pos: r_idx, val: cur_rd};
                            end
                            n_slot    = cur_rd;
                            ram_we    = 1'b1;
                            ram_waddr = cur_rd;
                            if (r_ord) begin
                                ram_wdata.tm = {r_cmd.new_hour, r_cmd.new_minute,
                                                r_cmd.new_second};
                            end else begin
                                ram_wdata.prio = r_cmd.new_priority;
                            end
                            n_idx   = '0;
                            n_lim   = r_count - CNTW'(1);
                            n_phase = dopq_pkg::PH_REINS;
                        end
                    end
                    dopq_pkg::PH_REINS: begin
                        if (r_ord) begin
                            ctl_t = '{ins: 1'b1, rem: 1'b0, pos: r_idx, val: r_slot};
                        end else begin
                            ctl_p = '{ins: 1'b1, rem: 1'b0, pos: r_idx, val: r_slot};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dopq_pkg::S_EMIT_RD: begin
                ram_raddr = r_slot;
            end
            dopq_pkg::S_EMIT_OUT: begin
                n_res    = make_res(dopq_pkg::ST_OK, ram_rdata, 1'b1, 1'b1);
                n_strobe = 1'b1;
                if (cur_func == dopq_pkg::F_POP_P || cur_func == dopq_pkg::F_POP_T) begin
                    ctl_p          = '{ins: 1'b0, rem: 1'b1, pos: p_find, val: r_slot};
                    ctl_t          = '{ins: 1'b0, rem: 1'b1, pos: t_find, val: r_slot};
                    n_used[r_slot] = 1'b0;
                    n_count        = r_count - CNTW'(1);
                end
            end
            dopq_pkg::S_LIST_RD: begin
                ram_raddr = cur_rd;
            end
            dopq_pkg::S_LIST_OUT: begin
                n_res    = make_res(dopq_pkg::ST_OK, ram_rdata, 1'b1,
                                    r_idx + CNTW'(1) == r_lim);
                n_strobe = 1'b1;
                n_idx    = r_idx + CNTW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dopq_pkg::S_IDLE;
            r_used   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_phase  <= dopq_pkg::PH_ADD_P;
            r_ord    <= 1'b0;
            r_idx    <= '0;
            r_lim    <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_phase  <= n_phase;
            r_ord    <= n_ord;
            r_idx    <= n_idx;
            r_lim    <= n_lim;
            r_hit    <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ent  <= n_ent;
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    assign busy     = (r_state != dopq_pkg::S_IDLE);
    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

// File: tb/tb_dual_order_process_queue.sv
`timescale 1ns / 1ps
// self-checking testbench for dual_order_process_queue: directed table, a fill to capacity, then random commands
// depends on dopq_pkg and the rtl top level; predicts every result beat in a local model

module tb_dual_order_process_queue;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    dopq_pkg::t_in  i_cmd;
    dopq_pkg::t_out o_res;
    logic           o_strobe;

    dual_order_process_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_res(o_res), .o_strobe(o_strobe)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // local copy of the queue contents
    logic [7:0]                 q_prio [dopq_pkg::CAPACITY];
    logic [dopq_pkg::TIMEW-1:0] q_time [dopq_pkg::CAPACITY];
    logic [15:0]                q_tag  [dopq_pkg::CAPACITY];
    logic                       q_used [dopq_pkg::CAPACITY];
    int                         prio_order [dopq_pkg::CAPACITY];
    int                         time_order [dopq_pkg::CAPACITY];
    int                         q_count;

    dopq_pkg::t_out pending_beats [$];
    int             mismatches;
    int             idle_cycles;

    function automatic dopq_pkg::t_out entry_beat(dopq_pkg::t_status st, int slot, bit lst);
        dopq_pkg::t_out r;
        r = '0;
        r.status = st;
        if (slot >= 0) begin
            r.out_priority = q_prio[slot];
            r.out_hour     = q_time[slot][16:12];
            r.out_minute   = q_time[slot][11:6];
            r.out_second   = q_time[slot][5:0];
            r.out_tag      = q_tag[slot];
            r.entry_valid  = 1'b1;
        end
        r.last = lst;
        return r;
    endfunction

    function automatic int prio_slot_pos(int n, logic [7:0] p);
        int i;
        i = 0;
        while (i < n && q_prio[prio_order[i]] > p) i++;
        return i;
    endfunction

    function automatic int time_slot_pos(int n, logic [dopq_pkg::TIMEW-1:0] t);
        int i;
        i = 0;
        while (i < n && q_time[time_order[i]] < t) i++;
        return i;
    endfunction

    task automatic rank_insert(bit by_prio, int n, int pos, int v);
        for (int i = n; i > pos; i--) begin
            if (by_prio) prio_order[i] = prio_order[i-1];
            else time_order[i] = time_order[i-1];
        end
        if (by_prio) prio_order[pos] = v;
        else time_order[pos] = v;
    endtask

    task automatic rank_remove(bit by_prio, int n, int pos);
        for (int i = pos; i + 1 < n; i++) begin
            if (by_prio) prio_order[i] = prio_order[i+1];
            else time_order[i] = time_order[i+1];
        end
    endtask

    // applies one command to the local queue and pushes its result beats
    task automatic predict_queue(dopq_pkg::t_in c);
        logic [dopq_pkg::TIMEW-1:0] tkey, tnew;
        int n, s, i, cnt;
        n = q_count;
        tkey = {c.hour, c.minute, c.second};
        tnew = {c.new_hour, c.new_minute, c.new_second};
        case (c.func)
            dopq_pkg::F_ADD: begin
                if (n >= dopq_pkg::CAPACITY) begin
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_FULL, -1, 1'b1));
                end else begin
                    s = 0;
                    while (q_used[s]) s++;
                    q_prio[s] = c.priority_req;
                    q_time[s] = tkey;
                    q_tag[s] = c.tag;
                    q_used[s] = 1'b1;
                    rank_insert(1'b1, n, prio_slot_pos(n, c.priority_req), s);
                    rank_insert(1'b0, n, time_slot_pos(n, tkey), s);
                    q_count = n + 1;
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_OK, s, 1'b1));
                end
            end
            dopq_pkg::F_POP_P, dopq_pkg::F_POP_T, dopq_pkg::F_PEEK_P, dopq_pkg::F_PEEK_T: begin
                if (n == 0) begin
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_EMPTY, -1, 1'b1));
                end else begin
                    s = (c.func == dopq_pkg::F_POP_P || c.func == dopq_pkg::F_PEEK_P) ?
                        prio_order[0] : time_order[0];
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_OK, s, 1'b1));
                    if (c.func == dopq_pkg::F_POP_P || c.func == dopq_pkg::F_POP_T) begin
                        i = 0;
                        while (prio_order[i] != s) i++;
                        rank_remove(1'b1, n, i);
                        i = 0;
                        while (time_order[i] != s) i++;
                        rank_remove(1'b0, n, i);
                        q_used[s] = 1'b0;
                        q_count = n - 1;
                    end
                end
            end
            dopq_pkg::F_CHG_P: begin
                i = 0;
                while (i < n && q_prio[prio_order[i]] != c.priority_req) i++;
                if (i >= n) begin
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_NOT_FOUND, -1, 1'b1));
                end else begin
                    s = prio_order[i];
                    rank_remove(1'b1, n, i);
                    q_prio[s] = c.new_priority;
                    rank_insert(1'b1, n - 1, prio_slot_pos(n - 1, c.new_priority), s);
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_OK, s, 1'b1));
                end
            end
            dopq_pkg::F_CHG_T: begin
                i = 0;
                while (i < n && q_time[time_order[i]] != tkey) i++;
                if (i >= n) begin
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_NOT_FOUND, -1, 1'b1));
                end else begin
                    s = time_order[i];
                    rank_remove(1'b0, n, i);
                    q_time[s] = tnew;
                    rank_insert(1'b0, n - 1, time_slot_pos(n - 1, tnew), s);
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_OK, s, 1'b1));
                end
            end
            dopq_pkg::F_LIST_P, dopq_pkg::F_LIST_T: begin
                cnt = (n < dopq_pkg::MAX_RESULTS) ? n : dopq_pkg::MAX_RESULTS;
                if (cnt == 0)
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_EMPTY, -1, 1'b1));
                for (i = 0; i < cnt; i++) begin
                    s = (c.func == dopq_pkg::F_LIST_P) ? prio_order[i] : time_order[i];
                    pending_beats.push_back(entry_beat(dopq_pkg::ST_OK, s, i + 1 == cnt));
                end
            end
            default: ;
        endcase
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", o_res);
            end else begin
                dopq_pkg::t_out exp_beat;
                exp_beat = pending_beats.pop_front();
                if (o_res !== exp_beat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_beat, o_res);
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic dopq_pkg::t_in make_cmd(dopq_pkg::t_func f, int p, int t,
                                               int tg, int np, int nt);
        dopq_pkg::t_in c;
        c.func = f;
        c.priority_req = 8'(p);
        {c.hour, c.minute, c.second} = 17'(t);
        c.tag = 16'(tg);
        c.new_priority = 8'(np);
        {c.new_hour, c.new_minute, c.new_second} = 17'(nt);
        return c;
    endfunction

    function automatic dopq_pkg::t_in random_cmd(bit calm_keys);
        dopq_pkg::t_in c;
        logic [95:0]   rnd;
        int            r;
        rnd = {$urandom, $urandom, $urandom};
        c = dopq_pkg::t_in'(rnd[$bits(dopq_pkg::t_in)-1:0]);
        r = $urandom_range(0, 99);
        if (r < 35) c.func = dopq_pkg::F_ADD;
        else if (r < 50) c.func = dopq_pkg::t_func'($urandom_range(1, 2));
        else if (r < 60) c.func = dopq_pkg::t_func'($urandom_range(3, 4));
        else if (r < 80) c.func = dopq_pkg::t_func'($urandom_range(5, 6));
        else if (r < 95) c.func = dopq_pkg::t_func'($urandom_range(7, 8));
        else c.func = 4'($urandom_range(9, 15));
        // narrow keys most of the time so changes find matches
        if (calm_keys) begin
            c.priority_req = 8'($urandom_range(0, 7));
            c.hour = 5'($urandom_range(0, 2));
            c.minute = 6'($urandom_range(0, 1));
            c.second = 6'($urandom_range(0, 1));
        end
        return c;
    endfunction

    // drives one command at the falling edge and waits until the queue is no longer busy
    task automatic issue_cmd(dopq_pkg::t_in c, bit with_gaps);
        while (with_gaps && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_queue(c);
        @(negedge i_clk);
    endtask

    dopq_pkg::t_in  directed [];
    dopq_pkg::t_out typed [];
    bit             has_typed [];

    initial begin
        dopq_pkg::t_out blank;
        mismatches = 0;
        idle_cycles = 0;
        q_count = 0;
        for (int i = 0; i < dopq_pkg::CAPACITY; i++) q_used[i] = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        blank = '0;
        directed = new[22];
        typed = new[22];
        has_typed = new[22];
        for (int i = 0; i < 22; i++) has_typed[i] = 1'b0;
        directed[0] = make_cmd(dopq_pkg::F_POP_P, 0, 0, 0, 0, 0);
        directed[1] = make_cmd(dopq_pkg::F_POP_T, 0, 0, 0, 0, 0);
        directed[2] = make_cmd(dopq_pkg::F_PEEK_P, 0, 0, 0, 0, 0);
        directed[3] = make_cmd(dopq_pkg::F_PEEK_T, 0, 0, 0, 0, 0);
        directed[4] = make_cmd(dopq_pkg::F_LIST_P, 0, 0, 0, 0, 0);
        directed[5] = make_cmd(dopq_pkg::F_CHG_P, 0, 0, 0, 9, 0);
        directed[6] = make_cmd(dopq_pkg::F_CHG_T, 0, 0, 0, 0, 5);
        for (int i = 0; i < 7; i++) has_typed[i] = 1'b1;
        typed[0] = blank; typed[0].status = dopq_pkg::ST_EMPTY; typed[0].last = 1'b1;
        typed[1] = typed[0]; typed[2] = typed[0]; typed[3] = typed[0]; typed[4] = typed[0];
        typed[5] = blank; typed[5].status = dopq_pkg::ST_NOT_FOUND; typed[5].last = 1'b1;
        typed[6] = typed[5];
        directed[7] = make_cmd(dopq_pkg::F_ADD, 8'hff, '1, 16'hffff, 0, 0);
        typed[7] = '1; typed[7].status = dopq_pkg::ST_OK;
        has_typed[7] = 1'b1;
        directed[8] = make_cmd(dopq_pkg::F_ADD, 0, 0, 0, 0, 0);
        directed[9] = make_cmd(dopq_pkg::F_ADD, 8'hff, 17'h1, 16'h1234, 0, 0);
        directed[10] = make_cmd(dopq_pkg::F_ADD, 8'h80, 17'h1, 16'h5678, 0, 0);
        directed[11] = make_cmd(dopq_pkg::F_PEEK_P, 0, 0, 0, 0, 0);
        directed[12] = make_cmd(dopq_pkg::F_PEEK_T, 0, 0, 0, 0, 0);
        directed[13] = make_cmd(dopq_pkg::F_CHG_P, 8'hff, 0, 0, 8'h00, 0);
        directed[14] = make_cmd(dopq_pkg::F_CHG_T, 0, 17'h1, 0, 0, '1);
        directed[15] = make_cmd(dopq_pkg::F_LIST_P, 0, 0, 0, 0, 0);
        directed[16] = make_cmd(dopq_pkg::F_LIST_T, 0, 0, 0, 0, 0);
        directed[17] = make_cmd(dopq_pkg::F_POP_P, 0, 0, 0, 0, 0);
        directed[18] = make_cmd(dopq_pkg::F_POP_T, 0, 0, 0, 0, 0);
        directed[19] = dopq_pkg::t_in'('1);
        directed[20] = make_cmd(dopq_pkg::F_LIST_T, 0, 0, 0, 0, 0);
        directed[21] = make_cmd(dopq_pkg::F_CHG_P, 8'h55, 0, 0, 1, 0);

        for (int i = 0; i < 22; i++) begin
            issue_cmd(directed[i], 1'b0);
            if (has_typed[i] && pending_beats.size() > 0)
                pending_beats[pending_beats.size() - 1] = typed[i];
        end

        // fill to capacity, then overflow it with the remaining adds
        for (int i = 0; i < dopq_pkg::CAPACITY + 2; i++) begin
            dopq_pkg::t_in c;
            c = random_cmd(1'b1);
            c.func = dopq_pkg::F_ADD;
            issue_cmd(c, 1'b1);
        end
        issue_cmd(make_cmd(dopq_pkg::F_LIST_P, 0, 0, 0, 0, 0), 1'b0);
        issue_cmd(make_cmd(dopq_pkg::F_LIST_T, 0, 0, 0, 0, 0), 1'b0);

        for (int i = 0; i < 78; i++)
            issue_cmd(random_cmd($urandom_range(0, 3) != 0), !(i >= 30 && i < 55));
        start <= 1'b0;

        while (pending_beats.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
